>>> design/smmv_pkg.sv
// ----------------------------------------------------------------------------
// Statistics unit package
// Shared output widths and the state type of the finishing sequencer.
// ----------------------------------------------------------------------------
package smmv_pkg;

    // Fixed widths of the result fields.
    localparam int OUT_SAMPLE_W = 16;
    localparam int VAR_W        = 32;
    localparam int COUNT_OUT_W  = 21;

    // Finishing sequencer steps.
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_MEAN,
        BK_DIV_MSQ,
        BK_SQRT,
        BK_MUL_NSQ,
        BK_MUL_SS,
        BK_SUB,
        BK_MUL_DEN,
        BK_DIV_VAR,
        BK_DONE
    } back_state_t;

endpackage

>>> design/stream_min_max_mean_var_rms_unit.sv
// Each result beat follows its marked beat through the squaring stage, the run
// queue and the bit-serial divider, square root and multiplier of the back end.
// Input takes one sample beat per cycle unless a finished run finds the queue
// full; the back end works on one run at a time until its result beat is taken,
// and the two-entry run queue absorbs runs meanwhile.
// Asynchronous active-low reset clears the front-end accumulators, the queue and the sequencer.
// ----------------------------------------------------------------------------
// Streaming statistics unit
// Running minimum, maximum, mean, sample variance and RMS over marked runs.
// ----------------------------------------------------------------------------
module stream_min_max_mean_var_rms_unit #(
    parameter int MAX_SAMPLES = 1048576,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   minimum,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   maximum,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   mean,
    output logic [smmv_pkg::VAR_W-1:0]          variance,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   rms,
    output logic [smmv_pkg::COUNT_OUT_W-1:0]    sample_count,
    output logic                                variance_valid,
    output logic                                overflowed
);

    import smmv_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW = SB + CW;
    localparam int SQW  = 2 * SB + CW;
    localparam int RECW = 2 * SB + CW + SUMW + SQW + 1;

    logic              push, q_full, pop, q_not_empty;
    logic [SB-1:0]     f_min, f_max, b_min, b_max;
    logic [CW-1:0]     f_count, b_count;
    logic [SUMW-1:0]   f_sum, b_sum;
    logic [SQW-1:0]    f_sumsq, b_sumsq;
    logic              f_ovf, b_ovf;
    logic [RECW-1:0]   q_din, q_dout;

    // Front end: accumulation.
    smmv_front #(
        .SB   (SB),
        .MAXS (MAX_SAMPLES),
        .CW   (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .last      (last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .push      (push),
        .rec_min   (f_min),
        .rec_max   (f_max),
        .rec_count (f_count),
        .rec_sum   (f_sum),
        .rec_sumsq (f_sumsq),
        .rec_ovf   (f_ovf)
    );

    // Run queue between the two halves.
    assign q_din = {f_min, f_max, f_count, f_sum, f_sumsq, f_ovf};
    assign {b_min, b_max, b_count, b_sum, b_sumsq, b_ovf} = q_dout;

    smmv_queue #(
        .W (RECW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (q_din),
        .full      (q_full),
        .pop       (pop),
        .dout      (q_dout),
        .not_empty (q_not_empty)
    );

    // Back end: final arithmetic and result beat.
    smmv_back #(
        .SB (SB),
        .CW (CW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .pop            (pop),
        .rec_min        (b_min),
        .rec_max        (b_max),
        .rec_count      (b_count),
        .rec_sum        (b_sum),
        .rec_sumsq      (b_sumsq),
        .rec_ovf        (b_ovf),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .minimum        (minimum),
        .maximum        (maximum),
        .mean           (mean),
        .variance       (variance),
        .rms            (rms),
        .sample_count   (sample_count),
        .variance_valid (variance_valid),
        .overflowed     (overflowed)
    );

endmodule

>>> design/smmv_front.sv
// ----------------------------------------------------------------------------
// Statistics unit front end
// Takes one sample per cycle unless stalled, squares it, and folds it into
// the running minimum, maximum, count, sum and sum of squares of the current run.
// ----------------------------------------------------------------------------
module smmv_front #(
    parameter int SB   = 16,
    parameter int MAXS = 1048576,
    parameter int CW   = 21
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SB-1:0]          sample,
    input  logic                   last,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   q_full,
    output logic                   push,
    output logic [SB-1:0]          rec_min,
    output logic [SB-1:0]          rec_max,
    output logic [CW-1:0]          rec_count,
    output logic [SB+CW-1:0]       rec_sum,
    output logic [2*SB+CW-1:0]     rec_sumsq,
    output logic                   rec_ovf
);

    localparam int SUMW = SB + CW;
    localparam int SQW  = 2 * SB + CW;

    logic              s1_valid_reg;
    logic [SB-1:0]     s1_sample_reg;
    logic [2*SB-1:0]   s1_sq_reg;
    logic              s1_last_reg;

    logic [SB-1:0]     min_reg, min_next;
    logic [SB-1:0]     max_reg, max_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SUMW-1:0]   sum_reg, sum_next;
    logic [SQW-1:0]    sumsq_reg, sumsq_next;
    logic              ovf_reg, ovf_next;

    logic              s1_go;
    logic              has_room;

    // The squaring stage holds only when a finished run cannot enter the queue.
    assign in_stall = s1_valid_reg & s1_last_reg & q_full;
    assign s1_go    = s1_valid_reg & ~in_stall;
    assign has_room = count_reg < CW'(MAXS);

    // Squaring stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_sample_reg <= sample;
            s1_sq_reg     <= (2*SB)'(sample) * (2*SB)'(sample);
            s1_last_reg   <= last;
        end
    end

    // Accumulator update; samples beyond capacity only raise the flag.
    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        if (has_room)
        begin
            if (s1_sample_reg < min_reg)
            begin
                min_next = s1_sample_reg;
            end
            if (s1_sample_reg > max_reg)
            begin
                max_next = s1_sample_reg;
            end
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUMW'(s1_sample_reg);
            sumsq_next = sumsq_reg + SQW'(s1_sq_reg);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // A finished run leaves as one queue entry.
    assign push      = s1_go & s1_last_reg;
    assign rec_min   = min_next;
    assign rec_max   = max_next;
    assign rec_count = count_next;
    assign rec_sum   = sum_next;
    assign rec_sumsq = sumsq_next;
    assign rec_ovf   = ovf_next;

    // Accumulators clear after the marked beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '1;
            max_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                min_reg   <= '1;
                max_reg   <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                min_reg   <= min_next;
                max_reg   <= max_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

>>> design/smmv_queue.sv
// ----------------------------------------------------------------------------
// Statistics unit run queue
// Two-entry queue of finished run totals between front and back end.
// ----------------------------------------------------------------------------
module smmv_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         not_empty
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign dout      = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> design/smmv_back.sv
// ----------------------------------------------------------------------------
// Statistics unit back end
// Bit-serial sequencer that turns run totals into mean, RMS and sample
// variance with one shift-add multiplier, one restoring divider and one
// restoring square root, then holds the result beat.
// ----------------------------------------------------------------------------
module smmv_back #(
    parameter int SB = 16,
    parameter int CW = 21
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_not_empty,
    output logic                                pop,
    input  logic [SB-1:0]                       rec_min,
    input  logic [SB-1:0]                       rec_max,
    input  logic [CW-1:0]                       rec_count,
    input  logic [SB+CW-1:0]                    rec_sum,
    input  logic [2*SB+CW-1:0]                  rec_sumsq,
    input  logic                                rec_ovf,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   minimum,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   maximum,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   mean,
    output logic [smmv_pkg::VAR_W-1:0]          variance,
    output logic [smmv_pkg::OUT_SAMPLE_W-1:0]   rms,
    output logic [smmv_pkg::COUNT_OUT_W-1:0]    sample_count,
    output logic                                variance_valid,
    output logic                                overflowed
);

    import smmv_pkg::*;

    localparam int SUMW    = SB + CW;
    localparam int SQW     = 2 * SB + CW;
    localparam int NW      = 2 * SB + 2 * CW;
    localparam int DW      = 2 * CW;
    localparam int CNTW    = $clog2(NW + 1);
    localparam int SH_MEAN = NW - SUMW;
    localparam int SH_MSQ  = NW - SQW;
    localparam int QW      = (NW > VAR_W) ? NW : VAR_W + 1;

    back_state_t state_reg, state_next;

    logic [SB-1:0]     min_reg, max_reg;
    logic [CW-1:0]     n_reg;
    logic [SUMW-1:0]   sum_reg;
    logic [SQW-1:0]    sumsq_reg;
    logic              ovf_reg;

    logic [NW-1:0]     acc_reg, cand_reg, prod_reg;
    logic [SUMW-1:0]   plier_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [DW-1:0]     den_reg, rem_reg;
    logic [NW-1:0]     src_reg, quot_reg;
    logic [SB-1:0]     mean_reg, root_reg;
    logic [2*SB-1:0]   msq_reg;
    logic [SB+1:0]     srem_reg;
    logic [VAR_W-1:0]  var_reg;

    logic              last_step;
    logic [NW-1:0]     acc_step;
    logic [DW:0]       div_trial;
    logic              div_ge;
    logic [DW-1:0]     rem_step;
    logic [NW-1:0]     quot_step;
    logic [SB+3:0]     sq_shift;
    logic [SB+3:0]     sq_trial;
    logic              sq_ge;
    logic [SB+1:0]     srem_step;
    logic [SB-1:0]     root_step;
    logic [QW-1:0]     quot_wide;
    logic [VAR_W-1:0]  var_sat;
    logic              n_ge2;

    assign last_step = cnt_reg == CNTW'(1);

    // Shift-add multiplier step.
    assign acc_step = acc_reg + (plier_reg[0] ? cand_reg : '0);

    // Restoring divider step: one quotient bit per cycle.
    assign div_trial = {rem_reg, src_reg[NW-1]};
    assign div_ge    = div_trial >= {1'b0, den_reg};
    assign rem_step  = div_ge ? DW'(div_trial - {1'b0, den_reg}) : DW'(div_trial);
    assign quot_step = {quot_reg[NW-2:0], div_ge};

    // Restoring square root step: one root bit per cycle.
    assign sq_shift  = {srem_reg, msq_reg[2*SB-1:2*SB-2]};
    assign sq_trial  = (SB+4)'({root_reg, 2'b01});
    assign sq_ge     = sq_shift >= sq_trial;
    assign srem_step = sq_ge ? (SB+2)'(sq_shift - sq_trial) : (SB+2)'(sq_shift);
    assign root_step = {root_reg[SB-2:0], sq_ge};

    // Variance saturates to the field width.
    assign quot_wide = QW'(quot_step);
    assign var_sat   = (|quot_wide[QW-1:VAR_W]) ? '1 : quot_wide[VAR_W-1:0];

    // Next state and handshake.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_DIV_MEAN;
                end
            end
            BK_DIV_MEAN: if (last_step) state_next = BK_DIV_MSQ;
            BK_DIV_MSQ:  if (last_step) state_next = BK_SQRT;
            BK_SQRT:     if (last_step) state_next = BK_MUL_NSQ;
            BK_MUL_NSQ:  if (last_step) state_next = BK_MUL_SS;
            BK_MUL_SS:   if (last_step) state_next = BK_SUB;
            BK_SUB:      state_next = BK_MUL_DEN;
            BK_MUL_DEN:  if (last_step) state_next = BK_DIV_VAR;
            BK_DIV_VAR:  if (last_step) state_next = BK_DONE;
            BK_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath: each step runs its unit and sets up the next one on its last cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    min_reg   <= rec_min;
                    max_reg   <= rec_max;
                    n_reg     <= rec_count;
                    sum_reg   <= rec_sum;
                    sumsq_reg <= rec_sumsq;
                    ovf_reg   <= rec_ovf;
                    den_reg   <= DW'(rec_count);
                    src_reg   <= NW'(rec_sum) << SH_MEAN;
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    cnt_reg   <= CNTW'(SUMW);
                end
            end
            BK_DIV_MEAN, BK_DIV_MSQ, BK_DIV_VAR:
            begin
                src_reg  <= src_reg << 1;
                rem_reg  <= rem_step;
                quot_reg <= quot_step;
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    if (state_reg == BK_DIV_MEAN)
                    begin
                        mean_reg <= SB'(quot_step);
                        src_reg  <= NW'(sumsq_reg) << SH_MSQ;
                        rem_reg  <= '0;
                        quot_reg <= '0;
                        cnt_reg  <= CNTW'(SQW);
                    end
                    else if (state_reg == BK_DIV_MSQ)
                    begin
                        msq_reg  <= (2*SB)'(quot_step);
                        srem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg  <= CNTW'(SB);
                    end
                    else
                    begin
                        var_reg <= var_sat;
                    end
                end
            end
            BK_SQRT:
            begin
                srem_reg <= srem_step;
                root_reg <= root_step;
                msq_reg  <= msq_reg << 2;
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    acc_reg   <= '0;
                    cand_reg  <= NW'(sumsq_reg);
                    plier_reg <= SUMW'(n_reg);
                    cnt_reg   <= CNTW'(CW);
                end
            end
            BK_MUL_NSQ, BK_MUL_SS, BK_MUL_DEN:
            begin
                acc_reg   <= acc_step;
                cand_reg  <= cand_reg << 1;
                plier_reg <= plier_reg >> 1;
                cnt_reg   <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    if (state_reg == BK_MUL_NSQ)
                    begin
                        prod_reg  <= acc_step;
                        acc_reg   <= '0;
                        cand_reg  <= NW'(sum_reg);
                        plier_reg <= sum_reg;
                        cnt_reg   <= CNTW'(SUMW);
                    end
                    else if (state_reg == BK_MUL_DEN)
                    begin
                        den_reg  <= DW'(acc_step);
                        src_reg  <= prod_reg;
                        rem_reg  <= '0;
                        quot_reg <= '0;
                        cnt_reg  <= CNTW'(NW);
                    end
                end
            end
            BK_SUB:
            begin
                // Numerator n*sumsq - sum*sum, then set up n*(n-1).
                prod_reg  <= prod_reg - acc_reg;
                acc_reg   <= '0;
                cand_reg  <= NW'(n_reg);
                plier_reg <= SUMW'(n_reg - 1'b1);
                cnt_reg   <= CNTW'(CW);
            end
            default:
            begin
            end
        endcase
    end

    // Result beat.
    assign n_ge2          = n_reg >= CW'(2);
    assign minimum        = OUT_SAMPLE_W'(min_reg);
    assign maximum        = OUT_SAMPLE_W'(max_reg);
    assign mean           = OUT_SAMPLE_W'(mean_reg);
    assign rms            = OUT_SAMPLE_W'(root_reg);
    assign variance       = n_ge2 ? var_reg : '0;
    assign sample_count   = COUNT_OUT_W'(n_reg);
    assign variance_valid = n_ge2;
    assign overflowed     = ovf_reg;

endmodule

>>> bench/stream_min_max_mean_var_rms_unit_test.sv
// ----------------------------------------------------------------------------
// Streaming statistics unit testbench
// Sends runs of samples with random idling on both sides. Each result beat is
// compared with a predicted set of statistics, field by field. Directed rows
// cover extremes and single-sample runs; random runs follow.
// ----------------------------------------------------------------------------
module stream_min_max_mean_var_rms_unit_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SAMPLES    = 1048576;

    typedef struct {
        logic [15:0] minimum;
        logic [15:0] maximum;
        logic [15:0] mean;
        logic [31:0] variance;
        logic [15:0] rms;
        logic [20:0] sample_count;
        logic        variance_valid;
        logic        overflowed;
    } run_stats_t;

    // One row of the directed table; has_golden marks rows whose result is
    // typed in by hand.
    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          has_golden;
        run_stats_t  golden;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] sample;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] mean;
    logic [31:0] variance;
    logic [15:0] rms;
    logic [20:0] sample_count;
    logic        variance_valid;
    logic        overflowed;

    run_stats_t  expected_stats[$];
    int          error_count;
    int          idle_cycles;
    bit          quiet_phase;

    // Running accumulators of the predictor.
    logic [15:0]  acc_min;
    logic [15:0]  acc_max;
    logic [20:0]  acc_count;
    logic [35:0]  acc_sum;
    logic [51:0]  acc_sum_sq;
    logic         acc_ovf;

    stream_min_max_mean_var_rms_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .minimum(minimum), .maximum(maximum), .mean(mean),
        .variance(variance), .rms(rms), .sample_count(sample_count),
        .variance_valid(variance_valid), .overflowed(overflowed)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic void clear_run();
        acc_min    = 16'hFFFF;
        acc_max    = 16'h0000;
        acc_count  = '0;
        acc_sum    = '0;
        acc_sum_sq = '0;
        acc_ovf    = 1'b0;
    endfunction

    // Folds one beat into the running statistics; returns 1 with the result
    // when the beat closes a run. Beats beyond capacity only raise the flag.
    function automatic bit fold_sample(input logic [15:0] s, input logic mark,
                                       output run_stats_t r);
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        logic [63:0]  msq;
        logic [63:0]  n;
        if (acc_count < 21'(MAX_SAMPLES))
        begin
            acc_min    = (s < acc_min) ? s : acc_min;
            acc_max    = (s > acc_max) ? s : acc_max;
            acc_count  = acc_count + 1;
            acc_sum    = acc_sum + s;
            acc_sum_sq = acc_sum_sq + 52'(32'(s) * 32'(s));
        end
        else
        begin
            acc_ovf = 1'b1;
        end
        if (!mark)
            return 0;
        n     = 64'(acc_count);
        msq   = 64'(acc_sum_sq) / n;
        r.minimum        = acc_min;
        r.maximum        = acc_max;
        r.mean           = 16'(64'(acc_sum) / n);
        r.rms            = 16'(floor_sqrt(msq));
        r.sample_count   = acc_count;
        r.variance_valid = (n >= 2);
        r.overflowed     = acc_ovf;
        r.variance       = '0;
        if (n >= 2)
        begin
            numer = 128'(n) * 128'(acc_sum_sq) - 128'(acc_sum) * 128'(acc_sum);
            denom = 128'(n) * 128'(n - 1);
            quot  = numer / denom;
            r.variance = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(quot);
        end
        clear_run();
        return 1;
    endfunction

    task automatic send_beat(input logic [15:0] s, input logic mark);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Records the prediction for a beat and hands it to the block.
    task automatic send_checked(input logic [15:0] s, input logic mark);
        run_stats_t r;
        if (fold_sample(s, mark, r))
            expected_stats.push_back(r);
        send_beat(s, mark);
    endtask

    task automatic report(input string field, input longint exp_v, input longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    // Result checking on every accepted output beat.
    always @(posedge clk)
    begin
        run_stats_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stats.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual min %0d",
                         $time, minimum);
                error_count++;
            end
            else
            begin
                e = expected_stats.pop_front();
                if (minimum !== e.minimum) report("minimum", e.minimum, minimum);
                if (maximum !== e.maximum) report("maximum", e.maximum, maximum);
                if (mean !== e.mean) report("mean", e.mean, mean);
                if (variance !== e.variance) report("variance", e.variance, variance);
                if (rms !== e.rms) report("rms", e.rms, rms);
                if (sample_count !== e.sample_count)
                    report("sample_count", e.sample_count, sample_count);
                if (variance_valid !== e.variance_valid)
                    report("variance_valid", e.variance_valid, variance_valid);
                if (overflowed !== e.overflowed)
                    report("overflowed", e.overflowed, overflowed);
            end
        end
    end

    // Receiver stalls in random bursts.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        stim_row_t  rows[$];
        stim_row_t  row;
        run_stats_t pred;
        int         run_len;
        int         shape;
        int         n_items;
        logic [15:0] s;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        last        = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        quiet_phase = 0;
        clear_run();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: single-sample runs at the extremes, then short runs.
        row.has_golden = 1;
        row.sample = 16'h0000; row.last = 1;
        row.golden = '{16'h0000, 16'h0000, 16'h0000, 32'd0, 16'h0000, 21'd1, 1'b0, 1'b0};
        rows.push_back(row);
        row.sample = 16'hFFFF; row.last = 1;
        row.golden = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 16'hFFFF, 21'd1, 1'b0, 1'b0};
        rows.push_back(row);
        row.sample = 16'h1000; row.last = 1;
        row.golden = '{16'h1000, 16'h1000, 16'h1000, 32'd0, 16'h1000, 21'd1, 1'b0, 1'b0};
        rows.push_back(row);
        row.has_golden = 0;
        begin
            logic [15:0] seq[] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                   16'h0001, 16'h0002, 16'h0003, 16'hAAAA, 16'h5555,
                                   16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF, 16'hFFFE,
                                   16'hFFFD, 16'h0000, 16'h0000};
            logic         mk[]  = '{0, 1, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1, 1, 0, 0, 1, 0, 1};
            foreach (seq[i])
            begin
                row.sample = seq[i];
                row.last   = mk[i];
                rows.push_back(row);
            end
        end

        foreach (rows[i])
        begin
            if (fold_sample(rows[i].sample, rows[i].last, pred))
                expected_stats.push_back(rows[i].has_golden ? rows[i].golden : pred);
            send_beat(rows[i].sample, rows[i].last);
        end

        // Random runs of varied length and content.
        n_items = 0;
        while (n_items < 650)
        begin
            if (n_items > 550)
                quiet_phase = 1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            shape = $urandom_range(0, 3);
            for (int k = 0; k < run_len; k++)
            begin
                case (shape)
                    0: s = 16'($urandom);
                    1: s = 16'($urandom_range(0, 15));
                    2: s = 16'($urandom_range(16'hFFF0, 16'hFFFF));
                    default: s = 16'($urandom_range(16'h0F00, 16'h1100));
                endcase
                send_checked(s, k == run_len - 1);
                n_items++;
            end
        end
        in_valid <= 1'b0;
        last     <= 1'b0;

        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/smmv_pkg.sv
design/smmv_front.sv
design/smmv_queue.sv
design/smmv_back.sv
design/stream_min_max_mean_var_rms_unit.sv
bench/stream_min_max_mean_var_rms_unit_test.sv
